/* design/vibrato_modulated_delay_unit_macros.svh */
// Assertion macros for the vibrato modulated delay unit.
// Relies on clk and arst_n being visible in the scope that uses them.
`ifndef VIBRATO_MODULATED_DELAY_UNIT_MACROS_SVH
`define VIBRATO_MODULATED_DELAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define VMD_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define VMD_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/vmd_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the vibrato unit.
// No dependencies.
package vmd_pkg;

	localparam int CHANNELS    = 16;
	localparam int CH_BITS     = 4;
	localparam int DELAY_DEPTH = 16384;
	localparam int DEPTH_BITS  = 14;
	localparam int SAMPLE_BITS = 24;
	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_BITS   = 10;
	localparam int ADDR_BITS   = CH_BITS + DEPTH_BITS;
	localparam int STORE_DEPTH = CHANNELS * DELAY_DEPTH;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam int WIDTH_SCALE_Q24      = 318767;
	// ceil(2^33 / 6), exact floor division by six below 2^31
	localparam logic [30:0] RECIP_SIX   = 31'd1431655766;

	// register indexes
	typedef logic [2:0] reg_index_t;
	localparam reg_index_t REG_BASE_FREQUENCY  = 3'd0;
	localparam reg_index_t REG_BASE_WIDTH      = 3'd1;
	localparam reg_index_t REG_BASE_FLANGER    = 3'd2;
	localparam reg_index_t REG_FREQUENCY_DEPTH = 3'd3;
	localparam reg_index_t REG_WIDTH_DEPTH     = 3'd4;
	localparam reg_index_t REG_FLANGER_DEPTH   = 3'd5;
	localparam reg_index_t REG_SAMPLE_RATE     = 3'd6;
	localparam reg_index_t REG_INVERSE_RATE    = 3'd7;

	typedef struct packed {
		logic [CH_BITS-1:0]            channel;
		logic signed [SAMPLE_BITS-1:0] audio_sample;
		logic signed [15:0]            frequency_cv;
		logic signed [15:0]            width_cv;
		logic signed [15:0]            flanger_cv;
	} item_in_t;

	typedef struct packed {
		logic [CH_BITS-1:0]            voice;
		logic signed [SAMPLE_BITS-1:0] output_sample;
	} item_out_t;

	typedef logic [14:0] sine_rom_t [0:SINE_DEPTH];

	// Build the quarter-wave table with a Q30 Taylor series, rounded to Q15
	function automatic sine_rom_t build_sine();
		sine_rom_t rom;
		logic [63:0] t, t2, r, s, e;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			t  = 64'(k) * HALF_PI_Q30 / 64'(SINE_DEPTH);
			t2 = (t * t) >> 30;
			r  = Q30_ONE;
			r  = Q30_ONE - ((t2 * r) >> 30) / 64'd110;
			r  = Q30_ONE - ((t2 * r) >> 30) / 64'd72;
			r  = Q30_ONE - ((t2 * r) >> 30) / 64'd42;
			r  = Q30_ONE - ((t2 * r) >> 30) / 64'd20;
			r  = Q30_ONE - ((t2 * r) >> 30) / 64'd6;
			s  = (t * r) >> 30;
			e  = (s + 64'd16384) >> 15;
			if (e > 64'd32767) begin
				e = 64'd32767;
			end
			rom[k] = e[14:0];
		end
		return rom;
	endfunction

endpackage

/* design/vibrato_modulated_delay_unit.sv */
// Vibrato modulated delay unit: per-channel LFO-swept delay tap with B-spline blend.
// Each accepted item runs through the sequencer states S_FREQ to S_OUT; a zero sample rate goes straight to S_OUT.
// No new item is accepted until the current one leaves S_OUT, as the single shared multiplier serves every step.
// Reset: registers load their defaults; a clearing pass zeroes all 262144 entries of the
// delay store, one entry a cycle, during which no item is accepted. Depends on vmd_pkg.
`include "vibrato_modulated_delay_unit_macros.svh"

module vibrato_modulated_delay_unit import vmd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       sample_valid,
	output logic       sample_stall,
	input  item_in_t   sample,
	output logic       result_valid,
	input  logic       result_stall,
	output item_out_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  reg_index_t cfg_index,
	input  logic [31:0] cfg_data
);

	// sequencer codes
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_FREQ = 5'd1;
	localparam logic [4:0] S_WID  = 5'd2;
	localparam logic [4:0] S_MIX  = 5'd3;
	localparam logic [4:0] S_SEED = 5'd4;
	localparam logic [4:0] S_SMUL = 5'd5;
	localparam logic [4:0] S_SADD = 5'd6;
	localparam logic [4:0] S_WS   = 5'd7;
	localparam logic [4:0] S_SN   = 5'd8;
	localparam logic [4:0] S_WSN  = 5'd9;
	localparam logic [4:0] S_TAP  = 5'd10;
	localparam logic [4:0] S_P2   = 5'd11;
	localparam logic [4:0] S_P3   = 5'd12;
	localparam logic [4:0] S_WT   = 5'd13;
	localparam logic [4:0] S_A0   = 5'd14;
	localparam logic [4:0] S_A1   = 5'd15;
	localparam logic [4:0] S_A2   = 5'd16;
	localparam logic [4:0] S_A3   = 5'd17;
	localparam logic [4:0] S_A4   = 5'd18;
	localparam logic [4:0] S_Q    = 5'd19;
	localparam logic [4:0] S_DIV  = 5'd20;
	localparam logic [4:0] S_DRY  = 5'd21;
	localparam logic [4:0] S_SUM  = 5'd22;
	localparam logic [4:0] S_OUT  = 5'd23;

	localparam sine_rom_t SINE_ROM = build_sine();

	// configuration registers and derived products
	logic [15:0] base_freq_q;
	logic [18:0] base_width_q;
	logic [15:0] base_flanger_q;
	logic [13:0] flanger_depth_q;
	logic [17:0] sample_rate_q;
	logic [31:0] inverse_rate_q;
	logic [18:0] freq_depth19_q;
	logic [32:0] width_depth_scaled_q;
	logic [32:0] gain_q;
	logic [34:0] gain_five;

	// control
	logic [4:0]           state_q;
	logic                 clr_busy_q;
	logic [ADDR_BITS-1:0] clr_addr_q;
	logic                 result_valid_q;
	item_out_t            result_q;

	// per-channel state
	logic [31:0]           phase_q [CHANNELS];
	logic [31:0]           smw_q   [CHANNELS];
	logic [DEPTH_BITS-1:0] wptr_q  [CHANNELS];

	// delay store
	logic [SAMPLE_BITS-1:0] dmem [0:STORE_DEPTH-1];
	logic                   mem_we;
	logic [ADDR_BITS-1:0]   waddr, raddr;
	logic [SAMPLE_BITS-1:0] wdata;

	// item datapath
	logic [CH_BITS-1:0]            ch_q;
	logic signed [SAMPLE_BITS-1:0] aud_q;
	logic signed [15:0]            fcv_q, wcv_q, gcv_q;
	logic [15:0]                   freq_q;
	logic [18:0]                   width_q;
	logic [15:0]                   mix_q;
	logic [31:0]                   sm_q;
	logic signed [33:0]            diff_q;
	logic [31:0]                   ph_q;
	logic [DEPTH_BITS-1:0]         wp_q;
	logic [14:0]                   sine_q;
	logic                          sneg_q;
	logic [28:0]                   ws_q;
	logic [31:0]                   tap_q;
	logic [31:0]                   p2_q;
	logic [26:0]                   w_q [4];
	logic signed [SAMPLE_BITS-1:0] rdata_q;
	logic signed [53:0]            acc_q;
	logic [28:0]                   xq_q;
	logic signed [27:0]            wet_q;
	logic signed [SAMPLE_BITS-1:0] res_q;
	logic                          silent_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	// combinational helpers
	logic signed [20:0] freq_sum;
	logic signed [23:0] width_sum;
	logic signed [19:0] mix_sum;
	logic [15:0]        freq_c, mix_c;
	logic [18:0]        width_c;
	logic [26:0]        width_t;
	logic [31:0]        sm_eff;
	logic signed [16:0] sn;
	logic [SINE_BITS:0] sidx_raw, sidx;
	logic [30:0]        sidx_sum;
	logic [15:0]        frac, whole;
	logic [51:0]        e0, e16, e32;
	logic [51:0]        wq0, wq1, wq2, wq3;
	logic [1:0]         tap_k;
	logic [1:0]         wt_k;
	logic [15:0]        back;
	logic [DEPTH_BITS-1:0] ridx;
	logic signed [53:0] acc_r;
	logic signed [30:0] xq_sum;
	logic signed [28:0] y_sum;
	logic signed [SAMPLE_BITS-1:0] y_sat;
	logic               accept, out_free;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE) || clr_busy_q;
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;
	assign gain_five    = {3'd0, cfg_data} + {1'b0, cfg_data, 2'd0};

	// configuration writes, with derived products formed at write time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_freq_q          <= 16'd10240;
			base_width_q         <= 19'd83886;
			base_flanger_q       <= 16'd0;
			flanger_depth_q      <= 14'd0;
			sample_rate_q        <= 18'd48000;
			inverse_rate_q       <= 32'd89478;
			freq_depth19_q       <= 19'd0;
			width_depth_scaled_q <= 33'd0;
			gain_q               <= 33'd447390;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BASE_FREQUENCY:  base_freq_q     <= cfg_data[15:0];
				REG_BASE_WIDTH:      base_width_q    <= cfg_data[18:0];
				REG_BASE_FLANGER:    base_flanger_q  <= cfg_data[15:0];
				REG_FREQUENCY_DEPTH: freq_depth19_q  <= 19'(cfg_data[13:0]) * 19'd19;
				REG_WIDTH_DEPTH:     width_depth_scaled_q <=
					33'(cfg_data[13:0]) * 33'(WIDTH_SCALE_Q24);
				REG_FLANGER_DEPTH:   flanger_depth_q <= cfg_data[13:0];
				REG_SAMPLE_RATE:     sample_rate_q   <= cfg_data[17:0];
				REG_INVERSE_RATE: begin
					inverse_rate_q <= cfg_data;
					gain_q <= (gain_five > 35'h1_0000_0000) ? 33'h1_0000_0000
					                                         : gain_five[32:0];
				end
				default: ;
			endcase
		end
	end

	// clamp the three control values
	always_comb begin
		freq_sum  = $signed({5'd0, base_freq_q}) + 21'($signed(prod_q[34:16]));
		width_sum = $signed({5'd0, base_width_q}) + 24'($signed(prod_q[48:27]));
		mix_sum   = $signed({4'd0, base_flanger_q}) + 20'($signed(prod_q[29:12]));
		if (freq_sum < 21'sd2048) begin
			freq_c = 16'd2048;
		end else if (freq_sum > 21'sd40960) begin
			freq_c = 16'd40960;
		end else begin
			freq_c = freq_sum[15:0];
		end
		if (width_sum < 24'sd16777) begin
			width_c = 19'd16777;
		end else if (width_sum > 24'sd335544) begin
			width_c = 19'd335544;
		end else begin
			width_c = width_sum[18:0];
		end
		if (mix_sum < 20'sd0) begin
			mix_c = 16'd0;
		end else if (mix_sum > 20'sd32768) begin
			mix_c = 16'd32768;
		end else begin
			mix_c = mix_sum[15:0];
		end
	end

	// seed the smoother and form sine index, spline weights and tap address
	always_comb begin
		width_t  = {width_q, 8'd0};
		sm_eff   = (sm_q == 32'd0) ? 32'(width_t) : sm_q;
		sidx_sum = {1'b0, ph_q[29:0]} + (31'd1 << (29 - SINE_BITS));
		sidx_raw = sidx_sum[30:30-SINE_BITS];
		sidx     = ph_q[30] ? ((SINE_BITS+1)'(SINE_DEPTH) - sidx_raw) : sidx_raw;
		sn       = sneg_q ? -$signed({2'd0, sine_q}) : $signed({2'd0, sine_q});
		frac     = tap_q[15:0];
		whole    = tap_q[31:16];
		e0       = 52'(prod_q[47:0]);
		e16      = 52'(p2_q) << 16;
		e32      = 52'(frac) << 32;
		wq0      = e0;
		wq1      = (52'd1 << 48) + e32 + (e32 << 1) + e16 + (e16 << 1) - e0 - (e0 << 1);
		wq2      = (52'd4 << 48) - (e16 << 2) - (e16 << 1) + e0 + (e0 << 1);
		wq3      = (52'd1 << 48) - e32 - (e32 << 1) + e16 + (e16 << 1) - e0;
		// tap_k addresses the next read, wt_k weights the sample already read
		case (state_q)
			S_A0: begin
				tap_k = 2'd1;
				wt_k  = 2'd0;
			end
			S_A1: begin
				tap_k = 2'd2;
				wt_k  = 2'd1;
			end
			S_A2: begin
				tap_k = 2'd3;
				wt_k  = 2'd2;
			end
			S_A3: begin
				tap_k = 2'd0;
				wt_k  = 2'd3;
			end
			default: begin
				tap_k = 2'd0;
				wt_k  = 2'd0;
			end
		endcase
		back     = whole - 16'(tap_k);
		ridx     = wp_q - back[DEPTH_BITS-1:0];
		raddr    = {ch_q, ridx};
		acc_r    = acc_q + 54'sd50331648;
		xq_sum   = 31'($signed(acc_r[53:24])) + 31'sd402653184;
		y_sum    = 29'(wet_q) + 29'($signed(prod_q[39:15]));
		if (y_sum > 29'sd8388607) begin
			y_sat = 24'sh7FFFFF;
		end else if (y_sum < -29'sd8388608) begin
			y_sat = -24'sh800000;
		end else begin
			y_sat = y_sum[23:0];
		end
	end

	// select operands of the shared multiplier
	always_comb begin
		case (state_q)
			S_FREQ: begin
				mul_a = 34'($signed({1'b0, freq_depth19_q}));
				mul_b = 34'(fcv_q);
			end
			S_WID: begin
				mul_a = $signed({1'b0, width_depth_scaled_q});
				mul_b = 34'(wcv_q);
			end
			S_MIX: begin
				mul_a = 34'($signed({1'b0, flanger_depth_q}));
				mul_b = 34'(gcv_q);
			end
			S_SEED: begin
				mul_a = 34'($signed({1'b0, freq_q}));
				mul_b = 34'($signed({1'b0, inverse_rate_q}));
			end
			S_SMUL: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, gain_q});
			end
			S_WS: begin
				mul_a = 34'($signed({1'b0, sm_q}));
				mul_b = 34'($signed({1'b0, sample_rate_q}));
			end
			S_WSN: begin
				mul_a = 34'($signed({1'b0, ws_q}));
				mul_b = 34'(sn);
			end
			S_P2: begin
				mul_a = 34'($signed({1'b0, frac}));
				mul_b = 34'($signed({1'b0, frac}));
			end
			S_P3: begin
				mul_a = 34'($signed({1'b0, prod_q[31:0]}));
				mul_b = 34'($signed({1'b0, frac}));
			end
			S_A0, S_A1, S_A2, S_A3: begin
				mul_a = 34'(rdata_q);
				mul_b = 34'($signed({1'b0, w_q[wt_k]}));
			end
			S_DIV: begin
				mul_a = 34'($signed({1'b0, xq_q}));
				mul_b = 34'($signed({1'b0, RECIP_SIX}));
			end
			S_DRY: begin
				mul_a = 34'(aud_q);
				mul_b = 34'($signed({1'b0, mix_q}));
			end
			default: begin
				mul_a = 34'sd0;
				mul_b = 34'sd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// delay store: one write port, one registered read port
	assign mem_we = clr_busy_q || (state_q == S_SADD);
	assign waddr  = clr_busy_q ? clr_addr_q : {ch_q, wp_q};
	assign wdata  = clr_busy_q ? '0 : aud_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[waddr] <= wdata;
		end
		rdata_q <= dmem[raddr];
		sine_q  <= SINE_ROM[sidx];
	end

	// sweep the delay store to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// sequencer, output register and per-channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				phase_q[c] <= '0;
				smw_q[c]   <= '0;
				wptr_q[c]  <= '0;
			end
		end else begin
			// drop the result once taken, unless a new one replaces it
			if (result_valid_q && !result_stall && (state_q != S_OUT)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (sample_rate_q == 18'd0) ? S_OUT : S_FREQ;
					end
				end
				S_OUT: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						if (!silent_q) begin
							phase_q[ch_q] <= ph_q;
							smw_q[ch_q]   <= sm_q;
							wptr_q[ch_q]  <= wp_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= state_q + 5'd1;
			endcase
		end
	end

	// item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ch_q     <= sample.channel;
				aud_q    <= sample.audio_sample;
				fcv_q    <= sample.frequency_cv;
				wcv_q    <= sample.width_cv;
				gcv_q    <= sample.flanger_cv;
				ph_q     <= phase_q[sample.channel];
				sm_q     <= smw_q[sample.channel];
				wp_q     <= wptr_q[sample.channel];
				silent_q <= (sample_rate_q == 18'd0);
				res_q    <= '0;
			end
			S_WID:  freq_q <= freq_c;
			S_MIX:  width_q <= width_c;
			S_SEED: begin
				mix_q  <= mix_c;
				sm_q   <= sm_eff;
				diff_q <= $signed({7'd0, width_t}) - $signed({2'd0, sm_eff});
			end
			S_SMUL: ph_q <= ph_q + prod_q[42:11];
			S_SADD: begin
				sm_q   <= sm_q + prod_q[63:32];
				sneg_q <= ph_q[31];
			end
			S_SN:   ws_q <= prod_q[44:16];
			S_TAP:  tap_q <= 32'h0004_0000 + 32'(ws_q) + 32'($signed(prod_q[46:15]));
			S_P3:   p2_q <= prod_q[31:0];
			S_WT: begin
				w_q[0] <= 27'((wq0 + 52'h80_0000) >> 24);
				w_q[1] <= 27'((wq1 + 52'h80_0000) >> 24);
				w_q[2] <= 27'((wq2 + 52'h80_0000) >> 24);
				w_q[3] <= 27'((wq3 + 52'h80_0000) >> 24);
			end
			S_A1:   acc_q <= 54'($signed(prod_q[50:0]));
			S_A2, S_A3, S_A4: acc_q <= acc_q + 54'($signed(prod_q[50:0]));
			S_Q:    xq_q <= xq_sum[28:0];
			S_DRY:  wet_q <= $signed({1'b0, prod_q[59:33]}) - 28'sd67108864;
			S_SUM:  res_q <= y_sat;
			S_OUT: begin
				if (out_free) begin
					result_q.voice         <= ch_q;
					result_q.output_sample <= res_q;
				end
			end
			default: ;
		endcase
	end

	`VMD_HOLDS(no_accept_while_clearing, clr_busy_q, sample_stall, "item accepted during clear")
	`VMD_NEXT(accept_starts_work, accept, state_q != S_IDLE, "accepted item not started")
	`VMD_NEXT(out_loads_result, (state_q == S_OUT) && out_free, (state_q == S_IDLE) && result_valid_q, "result not loaded")

endmodule

/* verif/vibrato_modulated_delay_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for vibrato_modulated_delay_unit: random and corner items,
// a bit-true predictor of the vibrato path, several register settings and random stalls.
// Depends on vmd_pkg and the unit itself.
module vibrato_modulated_delay_unit_tb;
	import vmd_pkg::*;

	localparam int LIMIT_CYCLES = 5000000;
	localparam int ITEMS_PER_SETTING = 257;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	item_in_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	item_out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	reg_index_t cfg_index = REG_BASE_FREQUENCY;
	logic [31:0] cfg_data = '0;

	vibrato_modulated_delay_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state: registers, per-voice LFO, smoother, pointer and delay memory
	longint unsigned base_freq = 10240, base_wid = 83886, base_mix = 0;
	longint unsigned freq_depth = 0, wid_depth = 0, mix_depth = 0;
	longint unsigned rate_hz = 48000, period_q32 = 89478;
	logic [31:0] lfo_phase_q [CHANNELS];
	logic [31:0] smooth_q32 [CHANNELS];
	int unsigned wr_ptr [CHANNELS];
	int delay_mem [CHANNELS][DELAY_DEPTH];
	int wave_rom [SINE_DEPTH+1];

	item_in_t pending_items[$];
	item_out_t expected_results[$];
	int gap_left = 0;
	bit calm = 1'b0;
	int items_sent = 0, results_seen = 0, mismatches = 0, settings_run = 0;
	int cycles = 0;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint floor_div(longint a, longint d);
		if (a >= 0) return a / d;
		return -((-a + d - 1) / d);
	endfunction

	function automatic longint sat24(longint v);
		return clamp(v, -(64'sd1 <<< 23), (64'sd1 <<< 23) - 1);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 45) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 70);
	endfunction

	// quarter-wave sine in Q15 by a Q30 Taylor series
	function automatic void fill_wave();
		longint unsigned t, t2, r, s;
		longint unsigned divs [5] = '{110, 72, 42, 20, 6};
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			t = longint'(k) * 64'd1686629713 / SINE_DEPTH;
			t2 = (t * t) >> 30;
			r = 64'd1 << 30;
			foreach (divs[i]) r = (64'd1 << 30) - ((t2 * r) >> 30) / divs[i];
			s = (((t * r) >> 30) + 64'd16384) >> 15;
			wave_rom[k] = s > 32767 ? 32767 : int'(s);
		end
	endfunction

	function automatic int voice_tap(int ch, int unsigned wp, longint back);
		longint unsigned b;
		b = longint'(back) % DELAY_DEPTH;
		return delay_mem[ch][(wp + DELAY_DEPTH - b) % DELAY_DEPTH];
	endfunction

	function automatic void apply_setting(reg_index_t idx, longint unsigned v);
		case (idx)
			REG_BASE_FREQUENCY:  base_freq = v & 64'hFFFF;
			REG_BASE_WIDTH:      base_wid = v & 64'h7FFFF;
			REG_BASE_FLANGER:    base_mix = v & 64'hFFFF;
			REG_FREQUENCY_DEPTH: freq_depth = v & 64'h3FFF;
			REG_WIDTH_DEPTH:     wid_depth = v & 64'h3FFF;
			REG_FLANGER_DEPTH:   mix_depth = v & 64'h3FFF;
			REG_SAMPLE_RATE:     rate_hz = v & 64'h3FFFF;
			default:             period_q32 = v & 64'hFFFFFFFF;
		endcase
	endfunction

	// one vibrato step for one voice; updates the predictor state unless the sample rate is zero
	function automatic item_out_t vibrato_predict(item_in_t it);
		item_out_t o;
		longint audio, freq, wid, mix, sm, ws, sn, tap, whole, frac;
		longint p3, a3, b3, c3, w0, w1, w2, w3, acc, wet, dry;
		longint unsigned gain, pos, idx;
		logic [31:0] ph;
		int ch;
		int unsigned wp;
		o.voice = it.channel;
		o.output_sample = '0;
		ch = it.channel;
		if (rate_hz == 0) return o;
		audio = longint'($signed(it.audio_sample));
		freq = clamp(longint'(base_freq) + ((longint'(freq_depth)
			* longint'($signed(it.frequency_cv)) * 19) >>> 16), 2048, 40960);
		wid = clamp(longint'(base_wid) + ((longint'(wid_depth)
			* longint'($signed(it.width_cv)) * 318767) >>> 27), 16777, 335544);
		mix = clamp(longint'(base_mix) + ((longint'(mix_depth)
			* longint'($signed(it.flanger_cv))) >>> 12), 0, 32768);
		// seed the smoother while it is zero, then move it towards the new width
		sm = longint'(smooth_q32[ch]);
		if (sm == 0) sm = wid * 256;
		gain = 5 * period_q32;
		if (gain > (64'd1 << 32)) gain = 64'd1 << 32;
		sm = sm + (((wid * 256 - sm) * longint'(gain)) >>> 32);
		smooth_q32[ch] = sm[31:0];
		ws = longint'((longint'(smooth_q32[ch]) * rate_hz) >> 16);
		// advance the LFO and look up the sine
		ph = lfo_phase_q[ch] + 32'((longint'(freq) * period_q32) >> 11);
		lfo_phase_q[ch] = ph;
		wp = wr_ptr[ch] % DELAY_DEPTH;
		delay_mem[ch][wp] = int'(audio);
		pos = ph[29:0];
		idx = (pos * SINE_DEPTH + (64'd1 << 29)) >> 30;
		if (idx > SINE_DEPTH) idx = SINE_DEPTH;
		if (ph[30]) idx = SINE_DEPTH - idx;
		sn = wave_rom[idx];
		if (ph[31]) sn = -sn;
		// B-spline blend of four taps around the modulated delay
		tap = (64'sd4 <<< 16) + ws + ((ws * sn) >>> 15);
		whole = tap >>> 16;
		frac = tap & 64'hFFFF;
		p3 = frac * frac * frac;
		a3 = (65536 + frac) * (65536 + frac) * (65536 + frac);
		b3 = (131072 - frac) * (131072 - frac) * (131072 - frac);
		c3 = (65536 - frac) * (65536 - frac) * (65536 - frac);
		w0 = (p3 + (64'sd1 <<< 23)) >>> 24;
		w1 = (a3 - 4 * p3 + (64'sd1 <<< 23)) >>> 24;
		w2 = (b3 - 4 * c3 + (64'sd1 <<< 23)) >>> 24;
		w3 = (c3 + (64'sd1 <<< 23)) >>> 24;
		acc = voice_tap(ch, wp, whole) * w0 + voice_tap(ch, wp, whole - 1) * w1
			+ voice_tap(ch, wp, whole - 2) * w2 + voice_tap(ch, wp, whole - 3) * w3;
		wet = floor_div(acc + (64'sd3 <<< 24), 64'sd6 <<< 24);
		dry = (audio * mix) >>> 15;
		o.output_sample = 24'(sat24(wet + dry));
		wr_ptr[ch] = (wp + 1) % DELAY_DEPTH;
		return o;
	endfunction

	// feed items from the pending queue, predicting each one as it is taken
	always @(posedge clk) begin
		logic next_valid;
		next_valid = sample_valid;
		if (sample_valid && !sample_stall) begin
			expected_results.push_back(vibrato_predict(pending_items.pop_front()));
			items_sent++;
			gap_left = pick_gap();
			next_valid = 1'b0;
		end
		if (!next_valid) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_items.size() > 0) begin
				next_valid = 1'b1;
				sample <= pending_items[0];
			end
		end
		sample_valid <= next_valid;
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		item_out_t want;
		if (result_valid && !result_stall) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: voice %0d sample %0d",
						result.voice, $signed(result.output_sample));
			end else begin
				want = expected_results.pop_front();
				if (want.voice !== result.voice
						|| want.output_sample !== result.output_sample) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch at result %0d: voice %0d/%0d sample %0d/%0d",
							results_seen, want.voice, result.voice,
							$signed(want.output_sample), $signed(result.output_sample));
				end
			end
		end
	end

	// receiver stalls: short random runs, plus one long hold-off mid run
	int stall_left = 0, free_left = 0, hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk) begin
		if (!hold_done && results_seen >= 1300) begin
			hold_done = 1'b1;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (free_left > 0) begin
			free_left--;
			result_stall <= 1'b0;
		end else begin
			result_stall <= 1'b0;
			free_left = pick_gap() + $urandom_range(0, 6);
			stall_left = pick_gap();
		end
	end

	// guard against a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_results.size());
			$display("vibrato_modulated_delay_unit_tb: FAIL");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_items.size() > 0 || expected_results.size() > 0 || sample_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_setting(longint unsigned vals [8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_data <= vals[i][31:0];
			do @(posedge clk); while (!cfg_ready);
			apply_setting(reg_index_t'(i), vals[i]);
			cfg_valid <= 1'b0;
		end
		settings_run++;
	endtask

	function automatic logic [15:0] pick_cv();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic queue_random(int n);
		item_in_t it;
		for (int i = 0; i < n; i++) begin
			// favour two voices so their delay lines fill with real audio
			it.channel = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 1)) : 4'($urandom);
			case ($urandom_range(0, 9))
				0: it.audio_sample = 24'h800000;
				1: it.audio_sample = 24'h7FFFFF;
				default: it.audio_sample = 24'($urandom);
			endcase
			it.frequency_cv = pick_cv();
			it.width_cv = pick_cv();
			it.flanger_cv = pick_cv();
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_corners();
		logic [15:0] cvs [3] = '{16'h8000, 16'h7FFF, 16'h0000};
		logic [23:0] auds [3] = '{24'h800000, 24'h7FFFFF, 24'h000000};
		foreach (auds[a]) begin
			foreach (cvs[c]) begin
				pending_items.push_back('{channel: (a == 1) ? 4'd15 : 4'd0,
					audio_sample: auds[a], frequency_cv: cvs[c], width_cv: cvs[2 - c],
					flanger_cv: cvs[c]});
			end
		end
	endtask

	initial begin
		longint unsigned vals [8];
		fill_wave();
		foreach (lfo_phase_q[i]) begin
			lfo_phase_q[i] = '0;
			smooth_q32[i] = '0;
			wr_ptr[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// defaults from reset
		queue_corners();
		queue_random(ITEMS_PER_SETTING - 9);
		wait_idle();
		// top of every range
		vals = '{40960, 335544, 32768, 13107, 13107, 13107, 192000, 22369};
		write_setting(vals);
		queue_corners();
		queue_random(ITEMS_PER_SETTING - 9);
		wait_idle();
		// bottom of every range, no idling
		calm = 1'b1;
		vals = '{2048, 16777, 0, 0, 0, 0, 8000, 536871};
		write_setting(vals);
		queue_random(ITEMS_PER_SETTING);
		wait_idle();
		calm = 1'b0;
		// out-of-range values: clamps bite, smoother gain saturates, phase wraps
		vals = '{65535, 524287, 65535, 16383, 16383, 16383, 262143, 32'hFFFFFFFF};
		write_setting(vals);
		queue_random(ITEMS_PER_SETTING);
		wait_idle();
		// zero sample rate gives silence
		vals = '{10240, 83886, 16384, 6000, 6000, 6000, 0, 89478};
		write_setting(vals);
		queue_random(ITEMS_PER_SETTING / 2);
		wait_idle();
		// random register bits
		for (int i = 0; i < 8; i++) vals[i] = $urandom;
		write_setting(vals);
		queue_random(ITEMS_PER_SETTING / 2);
		wait_idle();
		// typical setting, long run with the hold-off
		vals = '{10240, 83886, 16384, 6000, 6000, 6000, 48000, 89478};
		write_setting(vals);
		queue_random(2 * ITEMS_PER_SETTING);
		wait_idle();

		$display("%0d items over %0d register settings, %0d results checked, %0d cycles",
			items_sent, settings_run + 1, results_seen, cycles);
		if (mismatches == 0) begin
			$display("vibrato_modulated_delay_unit_tb: PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("vibrato_modulated_delay_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/vmd_pkg.sv
design/vibrato_modulated_delay_unit.sv
verif/vibrato_modulated_delay_unit_tb.sv
